// ----- hw/rtl/dra_pkg.sv -----
// Package for the DNS response address extractor.
// Holds the word types, parse phase encoding, status codes and field sizes.
// No dependencies.
package dra_pkg;

  // Input word: one response byte and the end-of-packet mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // Result word: address and end-of-packet report
  typedef struct packed {
    logic [31:0] address;
    logic        address_valid;
    logic        packet_done;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_NAME_LEN  = 4'd1,
    PH_NAME_SKIP = 4'd2,
    PH_QTAIL     = 4'd3,
    PH_ANS_START = 4'd4,
    PH_ANS_FIXED = 4'd5,
    PH_ANS_RDLEN = 4'd6,
    PH_ANS_SKIP  = 4'd7,
    PH_ANS_ADDR  = 4'd8,
    PH_IGNORE    = 4'd9
  } phase_t;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ID_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED   = 2'd2;

  localparam logic [3:0] HEADER_LAST     = 4'd11; // 12-byte header
  localparam logic [3:0] QTAIL_LAST      = 4'd3;  // qtype + qclass
  localparam logic [3:0] ANS_FIXED_LAST  = 4'd9;  // rest of pointer, type, class, ttl, rdlen hi
  localparam logic [3:0] ADDR_LAST       = 4'd3;
  localparam logic [7:0] NAME_POINTER    = 8'hC0;
  localparam logic [7:0] IPV4_RDLENGTH   = 8'd4;

endpackage

// ----- hw/rtl/dra_parser.sv -----
// Byte-at-a-time DNS response parser with the expected ID register.
// Depends on dra_pkg; produces at most one result word per accepted byte.
module dra_parser #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               take,
  input  dra_pkg::in_word_t  in_item,
  output logic               res_push,
  output dra_pkg::out_word_t res_item
);
  import dra_pkg::*;

  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

  logic [15:0]   expected_id;
  phase_t        phase, phase_next;
  logic [3:0]    byte_position, byte_position_next;
  logic [7:0]    id_high_byte, id_high_byte_next;
  logic [7:0]    skip_remaining, skip_remaining_next;
  logic [23:0]   address_shift, address_shift_next;
  logic          id_mismatch, id_mismatch_next;
  logic [CW-1:0] taken_count;
  logic          parse_en;
  logic          got;
  logic [31:0]   addr;
  logic [7:0]    b;
  logic [7:0]    skip_dec;

  assign b        = in_item.data_byte;
  assign parse_en = taken_count < CW'(MAX_PACKET_BYTES);
  assign skip_dec = skip_remaining - 8'd1;

  // Step the parse state for one byte
  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    id_high_byte_next   = id_high_byte;
    skip_remaining_next = skip_remaining;
    address_shift_next  = address_shift;
    id_mismatch_next    = id_mismatch;
    got                 = 1'b0;
    addr                = {address_shift, b};
    if (parse_en) begin
      case (phase)
        PH_HEADER: begin
          if (byte_position == 4'd0) begin
            id_high_byte_next = b;
          end
          if (byte_position == 4'd1 && {id_high_byte, b} != expected_id) begin
            id_mismatch_next = 1'b1;
            phase_next       = PH_IGNORE;
          end else if (byte_position == HEADER_LAST) begin
            byte_position_next = 4'd0;
            phase_next         = PH_NAME_LEN;
          end else begin
            byte_position_next = byte_position + 4'd1;
          end
        end
        PH_NAME_LEN: begin
          if (b == 8'd0) begin
            byte_position_next = 4'd0;
            phase_next         = PH_QTAIL;
          end else begin
            skip_remaining_next = b;
            phase_next          = PH_NAME_SKIP;
          end
        end
        PH_NAME_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_next = PH_NAME_LEN;
          end
        end
        PH_QTAIL: begin
          if (byte_position == QTAIL_LAST) begin
            byte_position_next = 4'd0;
            phase_next         = PH_ANS_START;
          end else begin
            byte_position_next = byte_position + 4'd1;
          end
        end
        PH_ANS_START: begin
          if (b == NAME_POINTER) begin
            byte_position_next = 4'd0;
            phase_next         = PH_ANS_FIXED;
          end else begin
            phase_next = PH_IGNORE;
          end
        end
        PH_ANS_FIXED: begin
          if (byte_position == ANS_FIXED_LAST) begin
            byte_position_next = 4'd0;
            phase_next         = PH_ANS_RDLEN;
          end else begin
            byte_position_next = byte_position + 4'd1;
          end
        end
        PH_ANS_RDLEN: begin
          if (b == IPV4_RDLENGTH) begin
            byte_position_next = 4'd0;
            address_shift_next = 24'd0;
            phase_next         = PH_ANS_ADDR;
          end else if (b == 8'd0) begin
            phase_next = PH_ANS_START;
          end else begin
            skip_remaining_next = b;
            phase_next          = PH_ANS_SKIP;
          end
        end
        PH_ANS_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_next = PH_ANS_START;
          end
        end
        PH_ANS_ADDR: begin
          if (byte_position >= ADDR_LAST) begin
            got                = 1'b1;
            address_shift_next = 24'd0;
            byte_position_next = 4'd0;
            phase_next         = PH_ANS_START;
          end else begin
            address_shift_next = {address_shift[15:0], b};
            byte_position_next = byte_position + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Build the result word from the post-byte state
  always_comb begin
    res_push               = take && (got || in_item.last_byte);
    res_item.address       = got ? addr : 32'd0;
    res_item.address_valid = got;
    res_item.packet_done   = in_item.last_byte;
    res_item.status        = STATUS_OK;
    if (in_item.last_byte) begin
      if (id_mismatch_next) begin
        res_item.status = STATUS_ID_MISMATCH;
      end else if (phase_next != PH_ANS_START && phase_next != PH_IGNORE) begin
        res_item.status = STATUS_TRUNCATED;
      end
    end
  end

  // Hold the expected transaction ID
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= 16'd0;
    end else if (cfg_write) begin
      expected_id <= cfg_data;
    end
  end

  // Advance the parse state; restart at the packet's last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_position  <= 4'd0;
      id_high_byte   <= 8'd0;
      skip_remaining <= 8'd0;
      address_shift  <= 24'd0;
      id_mismatch    <= 1'b0;
      taken_count    <= '0;
    end else if (take) begin
      if (in_item.last_byte) begin
        phase          <= PH_HEADER;
        byte_position  <= 4'd0;
        id_high_byte   <= 8'd0;
        skip_remaining <= 8'd0;
        address_shift  <= 24'd0;
        id_mismatch    <= 1'b0;
        taken_count    <= '0;
      end else begin
        phase          <= phase_next;
        byte_position  <= byte_position_next;
        id_high_byte   <= id_high_byte_next;
        skip_remaining <= skip_remaining_next;
        address_shift  <= address_shift_next;
        id_mismatch    <= id_mismatch_next;
        if (parse_en) begin
          taken_count <= taken_count + CW'(1);
        end
      end
    end
  end

endmodule

// ----- hw/rtl/dra_out_buf.sv -----
// Two-entry result buffer between the parser and the output channel.
// Depends on dra_pkg for the result word type.
module dra_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dra_pkg::out_word_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output dra_pkg::out_word_t out_item
);
  import dra_pkg::*;

  out_word_t  ent0, ent1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign full      = count == 2'd2;
  assign out_item  = ent0;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Shift entries toward the head
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          ent0 <= push_item;
        end else begin
          ent1 <= push_item;
        end
      end
      2'b01: begin
        ent0 <= ent1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          ent0 <= push_item;
        end else begin
          ent0 <= ent1;
          ent1 <= push_item;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/dns_response_address_extractor.sv -----
// Top level of the DNS response address extractor.
// Depends on dra_pkg, dra_parser and dra_out_buf.
//
// Takes a DNS response one byte per word and returns a word for every IPv4
// address found in a compressed-name answer record with rdlength 4, plus one
// word on the packet's last byte carrying the status (0 ok, 1 ID mismatch,
// 2 ended inside a field). The parser steps its state on each byte as it is
// accepted and writes any result into a two-entry output buffer, so one byte
// is accepted every clock while the output side keeps up, and in_ready drops
// only when both buffer entries are waiting.
// expected_id is written through the cfg channel, which is always ready;
// write it only between packets. Bytes past MAX_PACKET_BYTES are dropped.
module dns_response_address_extractor #(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  dra_pkg::in_word_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output dra_pkg::out_word_t out_item
);
  import dra_pkg::*;

  logic      take;
  logic      res_push;
  out_word_t res_item;
  logic      full;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign take      = in_valid && in_ready;

  // Parse each accepted byte
  dra_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .take     (take),
    .in_item  (in_item),
    .res_push (res_push),
    .res_item (res_item)
  );

  // Hold results for the output channel
  dra_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_item(res_item),
    .full     (full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule
